### rtl/sk128_pkg.sv
// sk128_pkg: shared types, tables and round function for the SKINNY-128-384 pipeline
package sk128_pkg;

  // default number of rounds of SKINNY-128-384
  localparam int ROUNDS_DEFAULT = 56;

  // width of the round-constant register
  localparam int RC_W = 6;

  // constant byte added to byte 8 every round
  localparam logic [7:0] C2_BYTE = 8'h02;

  // 16 bytes, byte 0 in the top bits
  typedef logic [0:15][7:0] blk_t;

  // one item as it travels down the chain
  typedef struct packed {
    blk_t            st;
    blk_t            tk1;
    blk_t            tk2;
    blk_t            tk3;
    logic [RC_W-1:0] rc;
  } word_t;

  // 8-bit s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
    8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
    8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
    8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
    8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
    8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
    8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
    8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
    8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
    8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
    8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
    8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
    8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
    8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
    8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
    8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
  };

  // tweakey byte permutation
  localparam int TK_PERM [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

  // permute the bytes of one tweakey word
  function automatic blk_t tk_permute(blk_t tk);
    blk_t o;
    for (int i = 0; i < 16; i++) begin
      o[i] = tk[TK_PERM[i]];
    end
    return o;
  endfunction

  // tk2 byte lfsr
  function automatic logic [7:0] lfsr2(logic [7:0] x);
    return {x[6:0], x[7] ^ x[5]};
  endfunction

  // tk3 byte lfsr
  function automatic logic [7:0] lfsr3(logic [7:0] x);
    return {x[0] ^ x[6], x[7:1]};
  endfunction

  // one full round plus the tweakey schedule step
  function automatic word_t round_f(word_t w);
    blk_t            s;
    blk_t            t;
    blk_t            m;
    logic [RC_W-1:0] rc;
    word_t           o;
    // sub cells
    for (int i = 0; i < 16; i++) begin
      s[i] = SBOX[w.st[i]];
    end
    // round constants
    rc = {w.rc[RC_W-2:0], w.rc[RC_W-1] ^ w.rc[RC_W-2] ^ 1'b1};
    s[0] = s[0] ^ {4'h0, rc[3:0]};
    s[4] = s[4] ^ {6'h0, rc[5:4]};
    s[8] = s[8] ^ C2_BYTE;
    // round tweakey on the top two rows
    for (int i = 0; i < 8; i++) begin
      s[i] = s[i] ^ w.tk1[i] ^ w.tk2[i] ^ w.tk3[i];
    end
    // shift rows, row r rotated right by r
    for (int i = 0; i < 16; i++) begin
      t[i] = s[((i >> 2) << 2) | (((i & 3) + 4 - (i >> 2)) & 3)];
    end
    // binary mix columns
    for (int c = 0; c < 4; c++) begin
      m[c]      = t[c] ^ t[8 + c] ^ t[12 + c];
      m[4 + c]  = t[c];
      m[8 + c]  = t[4 + c] ^ t[8 + c];
      m[12 + c] = t[c] ^ t[8 + c];
    end
    // tweakey schedule
    o.tk1 = tk_permute(w.tk1);
    o.tk2 = tk_permute(w.tk2);
    o.tk3 = tk_permute(w.tk3);
    for (int i = 0; i < 8; i++) begin
      o.tk2[i] = lfsr2(o.tk2[i]);
      o.tk3[i] = lfsr3(o.tk3[i]);
    end
    o.st = m;
    o.rc = rc;
    return o;
  endfunction

endpackage

### rtl/skinny_128_384_encrypt.sv
// skinny_128_384_encrypt: SKINNY-128-384 encryption as a chain of round cells
//
// channel  dir  fields (low bit up)
// s_axis   in   tdata: pt_hi, pt_lo, tk1_hi, tk1_lo, tk2_hi, tk2_lo, tk3_hi, tk3_lo
// m_axis   out  tdata: ct_hi, ct_lo
//
// one block per cycle sustained while m_axis_tready stays high; one cell per round
// each cell registers its round; the last cell is the output register
// a cell takes a new block when empty or when its block moves on, so bubbles close up
// rst clears the valid bit of every cell; payload registers are not reset
module skinny_128_384_encrypt #(
  parameter int ROUND_COUNT = sk128_pkg::ROUNDS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pt_hi, pt_lo, tk1_hi, tk1_lo, tk2_hi, tk2_lo, tk3_hi, tk3_lo
  input  logic [511:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ct_hi, ct_lo
  output logic [127:0] m_axis_tdata
);

  sk128_pkg::word_t w [ROUND_COUNT+1];
  logic             v [ROUND_COUNT+1];
  logic             r [ROUND_COUNT+1];
  logic [127:0]     ct;

  // unpack the input transfer, byte 0 of each word from the top of its hi field
  assign w[0].st  = {s_axis_tdata[63:0],    s_axis_tdata[127:64]};
  assign w[0].tk1 = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
  assign w[0].tk2 = {s_axis_tdata[319:256], s_axis_tdata[383:320]};
  assign w[0].tk3 = {s_axis_tdata[447:384], s_axis_tdata[511:448]};
  assign w[0].rc  = '0;
  assign v[0]     = s_axis_tvalid;
  assign s_axis_tready = r[0];

  // one cell per round
  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
    sk128_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (v[k]),
      .up_ready   (r[k]),
      .up_word    (w[k]),
      .valid      (v[k+1]),
      .down_ready (r[k+1]),
      .word       (w[k+1])
    );
  end

  // output side
  assign r[ROUND_COUNT] = m_axis_tready;
  assign m_axis_tvalid  = v[ROUND_COUNT];
  assign ct             = w[ROUND_COUNT].st;
  assign m_axis_tdata   = {ct[63:0], ct[127:64]};

`ifndef ASSERT_OFF
  // with the output register empty, no cell can hold back the input
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");
`endif

endmodule

### rtl/sk128_cell.sv
// sk128_cell: one registered round of the SKINNY-128-384 chain
module sk128_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  sk128_pkg::word_t up_word,
  output logic             valid,
  input  logic             down_ready,
  output sk128_pkg::word_t word
);

  logic load;

  // take a new item when empty or when the held one moves on
  assign up_ready = !valid || down_ready;
  assign load     = up_valid && up_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // round result
  always_ff @(posedge clk) begin
    if (load) begin
      word <= sk128_pkg::round_f(up_word);
    end
  end

`ifndef ASSERT_OFF
  // a held item stays put while the next cell is full
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !down_ready |=> valid && $stable(word))
    else $error("cell dropped or changed a held item");

  // a loaded item shows up as valid
  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("cell lost a loaded item");

  // an item that leaves without a replacement empties the cell
  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid && down_ready && !up_valid |=> !valid)
    else $error("cell repeated an item");
`endif

endmodule

### test/tb_skinny_128_384_encrypt.sv
// tb_skinny_128_384_encrypt: stream testbench for the SKINNY-128-384 encryption pipeline
module tb_skinny_128_384_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS = 56;

  // cell substitution table of the cipher
  localparam logic [7:0] CELL_SUB [256] = '{
    8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
    8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
    8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
    8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
    8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
    8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
    8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
    8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
    8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
    8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
    8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
    8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
    8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
    8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
    8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
    8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
  };

  // byte order of the tweakey schedule
  localparam int TK_ORDER [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pt_hi, pt_lo, tk1_hi, tk1_lo, tk2_hi, tk2_lo, tk3_hi, tk3_lo
  logic [511:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // ct_hi, ct_lo
  logic [127:0] m_axis_tdata;

  // ciphertexts still owed by the pipeline, oldest first
  logic [127:0] ct_q [$];

  int errors = 0;
  int blocks_sent = 0;
  int blocks_checked = 0;
  int in_stalls = 0;
  int hold_cycles = 0;
  bit rx_random = 1'b0;

  skinny_128_384_encrypt #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // ciphertext of one transfer, byte 0 of each word at the top of its hi field
  function automatic logic [127:0] skinny_ct(logic [511:0] blk);
    logic [7:0]   st [16];
    logic [7:0]   k1 [16];
    logic [7:0]   k2 [16];
    logic [7:0]   k3 [16];
    logic [7:0]   sh [16];
    logic [7:0]   p1 [16];
    logic [7:0]   p2 [16];
    logic [7:0]   p3 [16];
    logic [5:0]   rcon;
    logic [127:0] ct;
    int           base;
    rcon = '0;
    for (int i = 0; i < 16; i++) begin
      base  = 64 * (i / 8) + 63 - 8 * (i % 8);
      st[i] = blk[base -: 8];
      k1[i] = blk[128 + base -: 8];
      k2[i] = blk[256 + base -: 8];
      k3[i] = blk[384 + base -: 8];
    end
    for (int r = 0; r < ROUNDS; r++) begin
      for (int i = 0; i < 16; i++) begin
        st[i] = CELL_SUB[st[i]];
      end
      // round constant lfsr, stepped before use
      rcon  = {rcon[4:0], rcon[5] ^ rcon[4] ^ 1'b1};
      st[0] = st[0] ^ {4'h0, rcon[3:0]};
      st[4] = st[4] ^ {6'h0, rcon[5:4]};
      st[8] = st[8] ^ 8'h02;
      // round tweakey on the top two rows
      for (int i = 0; i < 8; i++) begin
        st[i] = st[i] ^ k1[i] ^ k2[i] ^ k3[i];
      end
      // tweakey schedule for the next round
      for (int i = 0; i < 16; i++) begin
        p1[i] = k1[TK_ORDER[i]];
        p2[i] = k2[TK_ORDER[i]];
        p3[i] = k3[TK_ORDER[i]];
      end
      for (int i = 0; i < 16; i++) begin
        k1[i] = p1[i];
        k2[i] = (i < 8) ? {p2[i][6:0], p2[i][7] ^ p2[i][5]} : p2[i];
        k3[i] = (i < 8) ? {p3[i][0] ^ p3[i][6], p3[i][7:1]} : p3[i];
      end
      // row r rotated right by r
      for (int i = 0; i < 16; i++) begin
        sh[i] = st[(i & 12) | (((i & 3) + 4 - (i >> 2)) & 3)];
      end
      // binary mixing of each column
      for (int c = 0; c < 4; c++) begin
        st[c]      = sh[c] ^ sh[8 + c] ^ sh[12 + c];
        st[4 + c]  = sh[c];
        st[8 + c]  = sh[4 + c] ^ sh[8 + c];
        st[12 + c] = sh[c] ^ sh[8 + c];
      end
    end
    for (int i = 0; i < 16; i++) begin
      ct[64 * (i / 8) + 63 - 8 * (i % 8) -: 8] = st[i];
    end
    return ct;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // random transfer, some fields forced to an extreme
  function automatic logic [511:0] random_block();
    logic [511:0] blk;
    for (int i = 0; i < 16; i++) begin
      blk[32 * i +: 32] = $urandom;
    end
    for (int f = 0; f < 8; f++) begin
      case ($urandom_range(0, 19))
        0: begin
          blk[64 * f +: 64] = '0;
        end
        1: begin
          blk[64 * f +: 64] = '1;
        end
        default: begin
        end
      endcase
    end
    return blk;
  endfunction

  // present one transfer and hold it until taken
  task automatic send_block(input logic [511:0] blk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    @(posedge clk);
    while (!s_axis_tready) begin
      in_stalls++;
      @(posedge clk);
    end
    ct_q.push_back(skinny_ct(blk));
    blocks_sent++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (ct_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // extremes of every field, one field at a time and all together
  task automatic test_field_extremes();
    logic [511:0] blk;
    rx_random = 1'b0;
    send_block('0);
    send_block('1);
    send_block({64{8'haa}});
    send_block({64{8'h55}});
    for (int f = 0; f < 8; f++) begin
      blk = '0;
      blk[64 * f +: 64] = '1;
      send_block(blk);
    end
    for (int f = 0; f < 8; f++) begin
      blk = '1;
      blk[64 * f +: 64] = 64'h8000_0000_0000_0001;
      send_block(blk);
    end
    idle_for(1);
    wait_drained();
  endtask

  // random traffic with gaps on both sides
  task automatic test_random_traffic(input int count);
    rx_random = 1'b1;
    for (int n = 0; n < count; n++) begin
      send_block(random_block());
      idle_for(pick_gap());
    end
  endtask

  // full rate on both sides
  task automatic test_full_rate(input int count);
    rx_random = 1'b0;
    for (int n = 0; n < count; n++) begin
      send_block(random_block());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the chain fills
  task automatic test_output_hold(input int count);
    rx_random   = 1'b0;
    hold_cycles = 300;
    for (int n = 0; n < count; n++) begin
      send_block(random_block());
    end
    rx_random = 1'b1;
  endtask

  // sender waits for every ciphertext before each short burst
  task automatic test_drain_pause(input int bursts);
    rx_random = 1'b1;
    for (int b = 0; b < bursts; b++) begin
      idle_for(1);
      wait_drained();
      for (int n = 0; n < 5; n++) begin
        send_block(random_block());
      end
    end
  endtask

  // result checker and receiver ready
  initial begin
    int stall_left;
    logic [127:0] want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (ct_q.size() == 0) begin
          $display("%0t: unexpected transfer ct_hi=%h ct_lo=%h", $time,
                   m_axis_tdata[63:0], m_axis_tdata[127:64]);
          errors++;
        end else begin
          want = ct_q.pop_front();
          blocks_checked++;
          if (m_axis_tdata[63:0] !== want[63:0]) begin
            $display("%0t: ct_hi expected %h actual %h", $time, want[63:0],
                     m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[127:64] !== want[127:64]) begin
            $display("%0t: ct_lo expected %h actual %h", $time, want[127:64],
                     m_axis_tdata[127:64]);
            errors++;
          end
        end
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_random) begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #(10ms);
    $display("tb_skinny_128_384_encrypt failed");
    $finish;
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_random_traffic(900);
    test_full_rate(200);
    test_output_hold(150);
    test_drain_pause(10);
    test_random_traffic(100);
    idle_for(1);
    wait_drained();
    repeat (ROUNDS + 20) @(posedge clk);
    $display("%0d blocks sent, %0d ciphertexts checked, %0d cycles of input stall",
             blocks_sent, blocks_checked, in_stalls);
    $display("covered field extremes, random keys, full rate, output hold and drain pauses");
    if (errors == 0 && ct_q.size() == 0) begin
      $display("tb_skinny_128_384_encrypt passed");
    end else begin
      $display("tb_skinny_128_384_encrypt failed");
    end
    $finish;
  end

endmodule
